FILE: design/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg: shared definitions for the scalar Kalman filter
// Widths, fixed-point constants, register map and controller command bundle.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int DATA_W    = 32;                    // sample / estimate width
    localparam int FRAC_BITS = 16;                    // Q format fraction bits
    localparam int GAIN_W    = FRAC_BITS + 1;         // gain spans 0..ONE
    localparam int DIFF_W    = DATA_W + 1;            // exact z - estimate
    localparam int DEN_W     = DATA_W + 1;            // pred + r
    localparam int REM_W     = DATA_W + 2;            // divider remainder
    localparam int PROD_W    = GAIN_W + 1 + DIFF_W;   // signed product
    localparam int SHR_W     = PROD_W - FRAC_BITS;    // product >>> FRAC_BITS
    localparam int SUM_W     = SHR_W + 1;             // estimate + correction
    localparam int CNT_W     = $clog2(GAIN_W);        // divider step counter

    localparam logic [GAIN_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // configuration map
    localparam int ADDR_W  = 3;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_PROCESS_NOISE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_MEASURE_NOISE = 1'b1;
    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd1310720;
    localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd13107200;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture measurement, predict covariance
        logic den;       // form denominator and innovation, seed divider
        logic div_step;  // one restoring-division step
        logic mul_gain;  // product = gain * innovation
        logic upd_est;   // update estimate, product = (ONE - gain) * pred
        logic upd_cov;   // update covariance, load result register
    } skf_cmd_t;

endpackage

FILE: design/skf_meas_if.sv
// ----------------------------------------------------------------------------
// skf_meas_if: measurement stream
// Valid/ready channel carrying one signed Q16.16 sample per transaction.
// ----------------------------------------------------------------------------
interface skf_meas_if;
    logic                              valid;
    logic                              ready;
    logic signed [skf_pkg::DATA_W-1:0] measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface

FILE: design/skf_filt_if.sv
// ----------------------------------------------------------------------------
// skf_filt_if: filtered estimate stream
// Valid/ready channel carrying one signed Q16.16 estimate per transaction.
// ----------------------------------------------------------------------------
interface skf_filt_if;
    logic                              valid;
    logic                              ready;
    logic signed [skf_pkg::DATA_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

FILE: design/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional Kalman filter, Q16.16 fixed point
//
// Usage:
//   sample (sink)  : one signed Q16.16 measurement per transaction.
//   result (source): one signed Q16.16 filtered estimate per sample.
//   APB port       : process_noise at 0x0, measure_noise at 0x4 (unsigned
//                    Q16.16); write only while no sample is in flight.
//   Sequence: the covariance prediction is captured on the transaction edge
//   itself; then the denominator is formed, the divider runs its 17 =
//   FRAC_BITS + 1 restoring steps at one quotient bit per cycle, and the
//   gain multiply, estimate update and covariance update follow, the last
//   raising the result. The sample port reopens in the same cycle as the
//   result is raised, so a new sample is taken only once the last is through.
//   Reset clears estimate and covariance to zero and loads the noise
//   registers with q = 20.0 and r = 200.0.
//   A stalled receiver holds the result register; the next sample is
//   still accepted and processed, and waits in its last phase until the
//   held result is taken.
// ----------------------------------------------------------------------------
module scalar_kalman_filter (
    input  logic                        clk,
    input  logic                        rst_n,
    skf_meas_if.sink                    sample,
    skf_filt_if.source                  result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [skf_pkg::ADDR_W-1:0]  paddr,
    input  logic [skf_pkg::DATA_W-1:0]  pwdata,
    output logic [skf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    logic [skf_pkg::DATA_W-1:0]    process_noise_reg, process_noise_next;
    logic [skf_pkg::DATA_W-1:0]    measure_noise_reg, measure_noise_next;
    logic [skf_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          wr_en;
    skf_pkg::skf_cmd_t             cmd;

    // APB register file: zero wait states, word index from paddr[2]
    assign pready  = 1'b1;
    assign reg_idx = paddr[skf_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        process_noise_next = process_noise_reg;
        measure_noise_next = measure_noise_reg;
        if (wr_en)
        begin
            case (reg_idx)
                skf_pkg::REG_PROCESS_NOISE: process_noise_next = pwdata;
                skf_pkg::REG_MEASURE_NOISE: measure_noise_next = pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            skf_pkg::REG_PROCESS_NOISE: prdata = process_noise_reg;
            skf_pkg::REG_MEASURE_NOISE: prdata = measure_noise_reg;
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_noise_reg <= skf_pkg::PROCESS_NOISE_RST;
            measure_noise_reg <= skf_pkg::MEASURE_NOISE_RST;
        end
        else
        begin
            process_noise_reg <= process_noise_next;
            measure_noise_reg <= measure_noise_next;
        end
    end

    // sequencer: one sample at a time, result register decoupled
    skf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // arithmetic and filter state
    skf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .measurement   (sample.measurement),
        .process_noise (process_noise_reg),
        .measure_noise (measure_noise_reg),
        .filtered      (result.filtered)
    );

endmodule

FILE: design/skf_ctrl.sv
// ----------------------------------------------------------------------------
// skf_ctrl: filter sequencer
// Steps one sample through predict, divide, multiply and update phases.
// ----------------------------------------------------------------------------
module skf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output skf_pkg::skf_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEN  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_EST  = 3'd4;
    localparam logic [2:0] S_COV  = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [skf_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEN;
                end
            end
            S_DEN:
            begin
                cmd.den    = 1'b1;
                cnt_next   = skf_pkg::CNT_W'(skf_pkg::GAIN_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_gain = 1'b1;
                state_next   = S_EST;
            end
            S_EST:
            begin
                cmd.upd_est = 1'b1;
                state_next  = S_COV;
            end
            S_COV:
            begin
                // wait for the result register to drain
                if (!out_valid_reg || out_ready)
                begin
                    cmd.upd_cov    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DEN))
        else $error("accepted sample did not start processing");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == '0) |=> (state_reg == S_MUL))
        else $error("divider did not finish after last step");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_COV))
        else $error("result raised outside the covariance update");

endmodule

FILE: design/skf_dp.sv
// ----------------------------------------------------------------------------
// skf_dp: filter datapath
// Estimate/covariance state, restoring divider and one shared multiplier.
// ----------------------------------------------------------------------------
module skf_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  skf_pkg::skf_cmd_t                 cmd,
    input  logic signed [skf_pkg::DATA_W-1:0] measurement,
    input  logic        [skf_pkg::DATA_W-1:0] process_noise,
    input  logic        [skf_pkg::DATA_W-1:0] measure_noise,
    output logic signed [skf_pkg::DATA_W-1:0] filtered
);

    localparam int DW = skf_pkg::DATA_W;
    localparam int FB = skf_pkg::FRAC_BITS;

    // state, cleared at reset
    logic signed [DW-1:0] est_reg, est_next;
    logic        [DW-1:0] cov_reg, cov_next;

    // working registers
    logic        [DW-1:0]                   pred_reg;
    logic signed [DW-1:0]                   z_reg;
    logic        [skf_pkg::DEN_W-1:0]       den_reg;
    logic                                   den_zero_reg;
    logic signed [skf_pkg::DIFF_W-1:0]      diff_reg;
    logic        [skf_pkg::REM_W-1:0]       rem_reg;
    logic        [skf_pkg::GAIN_W-1:0]      quo_reg;
    logic signed [skf_pkg::PROD_W-1:0]      prod_reg;
    logic signed [DW-1:0]                   filt_reg;

    logic [DW:0]                            pred_sum;
    logic [DW-1:0]                          pred_sat;
    logic [skf_pkg::DEN_W-1:0]              den_sum;
    logic                                   rem_ge;
    logic [skf_pkg::REM_W-1:0]              rem_sub;
    logic [skf_pkg::GAIN_W-1:0]             gain;
    logic [skf_pkg::GAIN_W-1:0]             mul_a;
    logic signed [skf_pkg::DIFF_W-1:0]      mul_b;
    logic signed [skf_pkg::PROD_W-1:0]      mul_p;
    logic signed [skf_pkg::SHR_W-1:0]       corr;
    logic signed [skf_pkg::SUM_W-1:0]       est_sum;
    logic                                   sat_hi, sat_lo;

    // predicted covariance, saturated
    assign pred_sum = {1'b0, cov_reg} + {1'b0, process_noise};
    assign pred_sat = pred_sum[DW] ? '1 : pred_sum[DW-1:0];

    assign den_sum  = {1'b0, pred_reg} + {1'b0, measure_noise};

    // restoring division step
    assign rem_ge  = (rem_reg >= {1'b0, den_reg});
    assign rem_sub = rem_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    assign gain = den_zero_reg ? '0 : quo_reg;

    // shared multiplier: gain * diff, then (ONE - gain) * pred
    always_comb
    begin
        if (cmd.upd_est)
        begin
            mul_a = skf_pkg::ONE - gain;
            mul_b = $signed({1'b0, pred_reg});
        end
        else
        begin
            mul_a = gain;
            mul_b = diff_reg;
        end
    end
    assign mul_p = $signed({1'b0, mul_a}) * mul_b;

    // estimate correction: floor shift, then saturate
    assign corr    = prod_reg[skf_pkg::PROD_W-1:FB];
    assign est_sum = {{(skf_pkg::SUM_W-DW){est_reg[DW-1]}}, est_reg}
                   + {corr[skf_pkg::SHR_W-1], corr};
    assign sat_hi  = !est_sum[skf_pkg::SUM_W-1] && (|est_sum[skf_pkg::SUM_W-2:DW-1]);
    assign sat_lo  =  est_sum[skf_pkg::SUM_W-1] && !(&est_sum[skf_pkg::SUM_W-2:DW-1]);

    always_comb
    begin
        est_next = est_reg;
        cov_next = cov_reg;
        if (cmd.upd_est)
        begin
            if (sat_hi)
                est_next = {1'b0, {(DW-1){1'b1}}};
            else if (sat_lo)
                est_next = {1'b1, {(DW-1){1'b0}}};
            else
                est_next = est_sum[DW-1:0];
        end
        if (cmd.upd_cov)
            cov_next = prod_reg[FB+DW-1:FB];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg <= '0;
            cov_reg <= '0;
        end
        else
        begin
            est_reg <= est_next;
            cov_reg <= cov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            z_reg    <= measurement;
            pred_reg <= pred_sat;
        end
        if (cmd.den)
        begin
            den_reg      <= den_sum;
            den_zero_reg <= (den_sum == '0);
            diff_reg     <= {z_reg[DW-1], z_reg} - {est_reg[DW-1], est_reg};
            rem_reg      <= {2'b00, pred_reg};
            quo_reg      <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= {rem_sub[skf_pkg::REM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[skf_pkg::GAIN_W-2:0], rem_ge};
        end
        if (cmd.mul_gain || cmd.upd_est)
            prod_reg <= mul_p;
        if (cmd.upd_cov)
            filt_reg <= est_reg;
    end

    assign filtered = filt_reg;

    a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.upd_cov) |-> (cov_reg <= pred_reg))
        else $error("covariance grew past its prediction");

endmodule
